>>> hdl/bfidc_pkg.sv
// ----------------------------------------------------------------------------
// bfidc_pkg
// shared types and constants for the blink frame id / color decoder
// ----------------------------------------------------------------------------
package bfidc_pkg;

	localparam int unsigned FrameBits = 5;
	localparam int unsigned LevelW    = 8;
	localparam int unsigned CfgIdxW   = 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_RED_THR  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_BLUE_THR = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LIFETIME = 2'd2;

	// register reset values
	localparam logic [LevelW-1:0] RED_THR_RST  = 8'd80;
	localparam logic [LevelW-1:0] BLUE_THR_RST = 8'd50;
	localparam logic [LevelW-1:0] LIFETIME_RST = 8'd60;

	// input command codes
	localparam logic CMD_SAMPLE   = 1'b0;
	localparam logic CMD_ACTIVATE = 1'b1;

	// id phase codes, all others act as decided
	localparam logic [2:0] PH_NONE    = 3'd0;
	localparam logic [2:0] PH_DECIDED = 3'd1;
	localparam logic [2:0] PH_VOTE_C  = 3'd2;
	localparam logic [2:0] PH_VOTE_B  = 3'd3;
	localparam logic [2:0] PH_VOTE_A  = 3'd4;

	typedef struct packed {
		logic [LevelW-1:0] red_thr;
		logic [LevelW-1:0] blue_thr;
		logic [LevelW-1:0] lifetime;
	} cfg_t;

	// packed lowest field last so that bit 0 is alive
	typedef struct packed {
		logic                 killed;
		logic [1:0]           color_code;
		logic                 color_valid;
		logic [1:0]           light_id;
		logic                 id_valid;
		logic                 parity_ok;
		logic [FrameBits-1:0] frame_value;
		logic                 frame_done;
		logic                 cursor_pressed;
		logic                 alive;
	} result_t;

endpackage

>>> hdl/bfidc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bfidc_cfg_regs
// threshold and lifetime registers behind the plain write port
// ----------------------------------------------------------------------------
module bfidc_cfg_regs
	import bfidc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [LevelW-1:0]  cfg_wdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_thr  <= RED_THR_RST;
			cfg_q.blue_thr <= BLUE_THR_RST;
			cfg_q.lifetime <= LIFETIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RED_THR:  cfg_q.red_thr  <= cfg_wdata;
				REG_BLUE_THR: cfg_q.blue_thr <= cfg_wdata;
				REG_LIFETIME: cfg_q.lifetime <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/bfidc_core.sv
// ----------------------------------------------------------------------------
// bfidc_core
// receiver state and one-step update: bit slicing, framing, id vote, color
// ----------------------------------------------------------------------------
module bfidc_core
	import bfidc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              cmd,
	input  logic [LevelW-1:0] red_level,
	input  logic [LevelW-1:0] blue_level,
	input  cfg_t              cfg,
	output result_t           res
);

	logic                 alive_q, alive_n;
	logic [FrameBits-1:0] shift_q, shift_n;
	logic [2:0]           cnt_q, cnt_n;
	logic [FrameBits-1:0] last_q, last_n;
	logic [LevelW-1:0]    dark_q, dark_n;
	logic [2:0]           phase_q, phase_n;
	logic                 idv_q, idv_n;
	logic [1:0]           id_q, id_n;
	logic                 colv_q, colv_n;
	logic [1:0]           col_q, col_n;
	logic                 cursor_q, cursor_n;
	logic [1:0]           slot_q [1:2];
	logic                 wr_slot2, wr_slot1;

	logic                 bit_in;
	logic [2:0]           cnt_inc;
	logic                 done;
	logic                 killed;
	logic [1:0]           idf;
	logic [1:0]           cnt [4];
	logic [1:0]           best;

	always_comb begin
		// id bits of the frame completing this step
		idf = shift_q[FrameBits-2:FrameBits-3];
		for (int i = 0; i < 4; i++) begin
			cnt[i] = 2'(slot_q[2] == 2'(i)) + 2'(slot_q[1] == 2'(i)) + 2'(idf == 2'(i));
		end
		best = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (cnt[i] > cnt[best]) begin
				best = 2'(i);
			end
		end
	end

	always_comb begin
		alive_n  = alive_q;
		shift_n  = shift_q;
		cnt_n    = cnt_q;
		last_n   = last_q;
		dark_n   = dark_q;
		phase_n  = phase_q;
		idv_n    = idv_q;
		id_n     = id_q;
		colv_n   = colv_q;
		col_n    = col_q;
		cursor_n = cursor_q;
		wr_slot2 = 1'b0;
		wr_slot1 = 1'b0;
		done     = 1'b0;
		killed   = 1'b0;
		bit_in   = red_level > cfg.red_thr;
		cnt_inc  = cnt_q + 3'd1;
		if (cmd == CMD_ACTIVATE) begin
			alive_n = 1'b1;
			phase_n = PH_VOTE_A;
		end else begin
			cursor_n = blue_level > cfg.blue_thr;
			if (bit_in) begin
				dark_n = '0;
			end else if (dark_q != '1) begin
				dark_n = dark_q + 8'd1;
			end
			if (!alive_q) begin
				if (bit_in) begin
					alive_n = 1'b1;
				end
			end else begin
				shift_n = {shift_q[FrameBits-2:0], bit_in};
				cnt_n   = cnt_inc;
				if (cnt_inc >= 3'(FrameBits)) begin
					last_n  = shift_n;
					shift_n = '0;
					cnt_n   = '0;
					done    = 1'b1;
					// used only with even parity
					if (!(^last_n)) begin
						case (phase_q)
							PH_VOTE_A: begin
								wr_slot2 = 1'b1;
								phase_n  = PH_VOTE_B;
							end
							PH_VOTE_B: begin
								wr_slot1 = 1'b1;
								phase_n  = PH_VOTE_C;
							end
							PH_VOTE_C: begin
								id_n    = best;
								idv_n   = 1'b1;
								phase_n = PH_DECIDED;
							end
							default: begin
								if (idv_q && id_q == last_n[4:3]) begin
									col_n  = last_n[2:1];
									colv_n = 1'b1;
								end
							end
						endcase
					end
				end
			end
			if (dark_n > cfg.lifetime) begin
				killed  = 1'b1;
				alive_n = 1'b0;
				shift_n = '0;
				cnt_n   = '0;
				last_n  = '0;
				dark_n  = '0;
				phase_n = PH_NONE;
				idv_n   = 1'b0;
				id_n    = '0;
				colv_n  = 1'b0;
				col_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q  <= 1'b0;
			shift_q  <= '0;
			cnt_q    <= '0;
			last_q   <= '0;
			dark_q   <= '0;
			phase_q  <= PH_NONE;
			idv_q    <= 1'b0;
			id_q     <= '0;
			colv_q   <= 1'b0;
			col_q    <= '0;
			cursor_q <= 1'b0;
		end else if (en) begin
			alive_q  <= alive_n;
			shift_q  <= shift_n;
			cnt_q    <= cnt_n;
			last_q   <= last_n;
			dark_q   <= dark_n;
			phase_q  <= phase_n;
			idv_q    <= idv_n;
			id_q     <= id_n;
			colv_q   <= colv_n;
			col_q    <= col_n;
			cursor_q <= cursor_n;
		end
	end

	// vote slots, undefined until written; the third vote is the current frame
	always_ff @(posedge clk) begin
		if (en && wr_slot2) begin
			slot_q[2] <= idf;
		end
		if (en && wr_slot1) begin
			slot_q[1] <= idf;
		end
	end

	always_comb begin
		res.alive          = alive_n;
		res.cursor_pressed = cursor_n;
		res.frame_done     = done;
		res.frame_value    = last_n;
		res.parity_ok      = ~(^last_n);
		res.id_valid       = idv_n;
		res.light_id       = idv_n ? id_n : 2'd0;
		res.color_valid    = colv_n;
		res.color_code     = colv_n ? col_n : 2'd0;
		res.killed         = killed;
	end

`ifndef ASSERT_OFF
	a_kill_clears : assert property (@(posedge clk) disable iff (!arst_n)
		en && killed |=> !alive_q && !idv_q && !colv_q && dark_q == '0)
		else $error("kill left receiver state behind");

	a_color_needs_id : assert property (@(posedge clk) disable iff (!arst_n)
		colv_q |-> idv_q)
		else $error("color valid without a decided id");

	a_frame_resets_count : assert property (@(posedge clk) disable iff (!arst_n)
		en && done |=> cnt_q == '0 && shift_q == '0)
		else $error("frame completion did not restart framing");

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < 3'(FrameBits))
		else $error("bit count past frame length");
`endif

endmodule

>>> hdl/blink_frame_id_color_decoder.sv
// ----------------------------------------------------------------------------
// blink_frame_id_color_decoder
// receiver for one tracked blinking light: id vote and color from 5-bit frames
// ----------------------------------------------------------------------------
// usage
//   s_* carries one item per transfer: s_tuser is the command (sample or
//   activate), s_tdata the red and blue levels at the light. m_* returns one
//   status item for every input item, in order.
//   cfg_we / cfg_index / cfg_wdata write the red threshold, blue threshold and
//   dark lifetime; write only while the block is idle.
// throughput
//   one item per cycle sustained while m_tready stays high. an accepted item is
//   held in the input register, its status is computed by the receiver update and
//   lands in the output register, which drives m_tvalid.
// reset
//   arst_n clears the light to dead with no id or color and restores the
//   register defaults (80, 50, 60). both channels come up empty.
// stalls
//   while m_tready is low the held result stays put, one further item waits in
//   the input register and s_tready drops until the output moves on.
// ----------------------------------------------------------------------------
module blink_frame_id_color_decoder
	import bfidc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,   // red_level[7:0], blue_level[15:8]
	input  logic [0:0]         s_tuser,   // command[0]
	output logic               m_tvalid,
	input  logic               m_tready,
	// alive[0], cursor_pressed[1], frame_done[2], frame_value[7:3], parity_ok[8],
	// id_valid[9], light_id[11:10], color_valid[12], color_code[14:13], killed[15]
	output logic [15:0]        m_tdata,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [LevelW-1:0]  cfg_wdata
);

	cfg_t              cfg;
	logic              valid_s1;
	logic              cmd_s1;
	logic [LevelW-1:0] red_s1;
	logic [LevelW-1:0] blue_s1;
	logic              advance;
	result_t           res;
	result_t           res_s2;
	logic              valid_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser[0];
			red_s1  <= s_tdata[7:0];
			blue_s1 <= s_tdata[15:8];
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	bfidc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bfidc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.cmd        (cmd_s1),
		.red_level  (red_s1),
		.blue_level (blue_s1),
		.cfg        (cfg),
		.res        (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

endmodule
